// ===== rtl/cad_pkg.sv =====
`default_nettype none
package cad_pkg;

  localparam int unsigned MAX_DIM_DEF = 256;
  localparam int unsigned LEN_W       = 9;
  localparam int unsigned VAL_W       = 16;
  localparam int unsigned DIST_W      = 16;
  localparam int unsigned DOT_W       = 40;
  localparam int unsigned NORM_W      = 39;
  localparam int unsigned PROD_W      = 2 * NORM_W;
  localparam int unsigned ROOT_W      = 40;
  localparam int unsigned CORD_W      = 56;
  localparam int unsigned ANG_W       = 27;
  localparam int unsigned CORD_STEPS  = 22;
  localparam int unsigned NORM_LIM_BIT = 50;
  localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;
  localparam logic [PROD_W-1:0] DEGEN_LIMIT = 78'd1152921;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 27'sd8388608;

  // Sums of one finished vector, handed from the front to the back.
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [NORM_W-1:0]       n1;
    logic [NORM_W-1:0]       n2;
  } acc_set_t;

  // round(atan(2^-i) * 2^24 / pi)
  function automatic logic [22:0] atan_tab(input logic [4:0] idx);
    logic [22:0] v;
    case (idx)
      5'd0:  v = 23'd4194304;
      5'd1:  v = 23'd2476042;
      5'd2:  v = 23'd1308273;
      5'd3:  v = 23'd664100;
      5'd4:  v = 23'd333339;
      5'd5:  v = 23'd166832;
      5'd6:  v = 23'd83436;
      5'd7:  v = 23'd41721;
      5'd8:  v = 23'd20861;
      5'd9:  v = 23'd10430;
      5'd10: v = 23'd5215;
      5'd11: v = 23'd2608;
      5'd12: v = 23'd1304;
      5'd13: v = 23'd652;
      5'd14: v = 23'd326;
      5'd15: v = 23'd163;
      5'd16: v = 23'd81;
      5'd17: v = 23'd41;
      5'd18: v = 23'd20;
      5'd19: v = 23'd10;
      5'd20: v = 23'd5;
      5'd21: v = 23'd3;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cad_if.sv =====
`default_nettype none
interface cad_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [cad_pkg::VAL_W-1:0]       first_value;
  logic signed [cad_pkg::VAL_W-1:0]       second_value;
  modport source(output valid, first_value, second_value, input ready);
  modport sink(input valid, first_value, second_value, output ready);
endinterface

interface cad_out_if;
  logic                         valid;
  logic                         ready;
  logic [cad_pkg::DIST_W-1:0]   distance;
  logic                         degenerate;
  modport source(output valid, distance, degenerate, input ready);
  modport sink(input valid, distance, degenerate, output ready);
endinterface
`default_nettype wire

// ===== rtl/cosine_angular_distance_top.sv =====
// Cosine angular distance between two streamed vectors.
//
// in_chan  : one element pair per transfer (first_value, second_value, Q1.15).
// out_chan : one result per vector: distance = angle/pi in Q0.16 and a
//            degenerate flag, set with distance 0 when the norm product is tiny.
// cfg_wr_en/cfg_wr_data : vector_length, 0 acts as 1, above MAX_DIM saturates.
//            Write only while the block is idle.
//
// Throughput: the front takes one pair per cycle (one 16x16 MAC per sum) as
// long as the two-entry job queue has room. The back takes the job, forms
// N1*N2 and then subtracts D*D on a shared shift-add multiplier, takes a
// bit-serial square root, normalizes, runs 22 CORDIC steps and loads the
// output register, handling one vector at a time. Degenerate vectors skip
// from the N1*N2 product to the output, skipping the square root and CORDIC.
// Reset clears the sums, the element count, the queue and the output, and sets
// vector_length to 256. When the receiver stalls, hold the result; the back
// keeps working on the next job up to S_DONE, and the front stalls once the queue fills.
`default_nettype none
module cosine_angular_distance_top #(
  parameter int unsigned MAX_DIM = cad_pkg::MAX_DIM_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [cad_pkg::LEN_W-1:0]  cfg_wr_data,
  cad_in_if.sink                          in_chan,
  cad_out_if.source                       out_chan
);

  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_not_empty;
  cad_pkg::acc_set_t push_data;
  cad_pkg::acc_set_t q_head;

  // Accumulate sums; hand each finished vector to the queue.
  cad_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  // Decouple the accumulator from the finishing unit.
  cad_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Products, square root, CORDIC angle and output register.
  cad_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (pop),
    .out_chan    (out_chan)
  );

endmodule
`default_nettype wire

// ===== rtl/cad_front.sv =====
`default_nettype none
module cad_front #(
  parameter int unsigned MAX_DIM = cad_pkg::MAX_DIM_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [cad_pkg::LEN_W-1:0]  cfg_wr_data,
  cad_in_if.sink                          in_chan,
  input  wire logic                       q_full,
  output logic                            push,
  output cad_pkg::acc_set_t               push_data
);

  localparam logic [cad_pkg::LEN_W-1:0] LEN_CAP =
    (MAX_DIM > 511) ? 9'd511 : cad_pkg::LEN_W'(MAX_DIM);

  logic [cad_pkg::LEN_W-1:0]           vlen_r;
  logic [cad_pkg::LEN_W-1:0]           cnt_r;
  logic [cad_pkg::LEN_W-1:0]           cnt_nxt;
  logic [cad_pkg::LEN_W-1:0]           len_eff;
  logic signed [cad_pkg::DOT_W-1:0]    dot_r;
  logic [cad_pkg::NORM_W-1:0]          n1_r;
  logic [cad_pkg::NORM_W-1:0]          n2_r;
  logic signed [31:0]                  p_ab;
  logic signed [31:0]                  p_aa;
  logic signed [31:0]                  p_bb;
  logic                                take;
  logic                                last;
  cad_pkg::acc_set_t                   sum;

  assign in_chan.ready = !q_full;
  assign take = in_chan.valid && in_chan.ready;

  always_comb begin
    if (vlen_r == '0) begin
      len_eff = 9'd1;
    end else if (vlen_r > LEN_CAP) begin
      len_eff = LEN_CAP;
    end else begin
      len_eff = vlen_r;
    end
  end

  assign p_ab = in_chan.first_value * in_chan.second_value;
  assign p_aa = in_chan.first_value * in_chan.first_value;
  assign p_bb = in_chan.second_value * in_chan.second_value;

  assign sum.dot = dot_r + cad_pkg::DOT_W'(p_ab);
  assign sum.n1  = n1_r + cad_pkg::NORM_W'(p_aa[30:0]);
  assign sum.n2  = n2_r + cad_pkg::NORM_W'(p_bb[30:0]);

  assign cnt_nxt = cnt_r + 9'd1;
  assign last    = cnt_nxt >= len_eff;

  assign push      = take && last;
  assign push_data = sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= cad_pkg::LEN_RESET;
      cnt_r  <= '0;
      dot_r  <= '0;
      n1_r   <= '0;
      n2_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        vlen_r <= cfg_wr_data;
      end
      if (take) begin
        if (last) begin
          cnt_r <= '0;
          dot_r <= '0;
          n1_r  <= '0;
          n2_r  <= '0;
        end else begin
          cnt_r <= cnt_nxt;
          dot_r <= sum.dot;
          n1_r  <= sum.n1;
          n2_r  <= sum.n2;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cad_queue.sv =====
`default_nettype none
module cad_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  cad_pkg::acc_set_t       push_data,
  input  wire logic               pop,
  output logic                    full,
  output logic                    not_empty,
  output cad_pkg::acc_set_t       head
);

  cad_pkg::acc_set_t ent_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue underflow");
`endif

endmodule
`default_nettype wire

// ===== rtl/cad_back.sv =====
`default_nettype none
module cad_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_not_empty,
  input  cad_pkg::acc_set_t   q_head,
  output logic                q_pop,
  cad_out_if.source           out_chan
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MULP = 7'b0000010,
    S_MULD = 7'b0000100,
    S_SQRT = 7'b0001000,
    S_NORM = 7'b0010000,
    S_CORD = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  localparam int unsigned PW = cad_pkg::PROD_W;
  localparam int unsigned CW = cad_pkg::CORD_W;
  localparam int unsigned RW = cad_pkg::ROOT_W;
  localparam int unsigned AW = cad_pkg::ANG_W;
  localparam logic [CW-1:0] NORM_LIM = CW'(1) << cad_pkg::NORM_LIM_BIT;

  state_t                        state_r;
  logic signed [cad_pkg::DOT_W-1:0] dot_r;
  logic [PW-1:0]                 acc_r;
  logic [PW-1:0]                 mcand_r;
  logic [cad_pkg::NORM_W-1:0]    mplr_r;
  logic [5:0]                    cnt_r;
  logic [2*RW-1:0]               rad_r;
  logic [RW+3:0]                 rem_r;
  logic [RW-1:0]                 root_r;
  logic signed [CW-1:0]          x_r;
  logic signed [CW-1:0]          y_r;
  logic signed [AW-1:0]          z_r;
  logic                          degen_r;
  logic                          out_valid_r;
  logic [cad_pkg::DIST_W-1:0]    out_dist_r;
  logic                          out_degen_r;

  logic [PW-1:0]                 acc_add;
  logic [PW-1:0]                 acc_sub;
  logic [cad_pkg::NORM_W-1:0]    dot_mag;
  logic [RW+3:0]                 rem_sh;
  logic [RW+3:0]                 trial;
  logic [CW-1:0]                 x_mag;
  logic signed [CW-1:0]          xs;
  logic signed [CW-1:0]          ys;
  logic signed [AW-1:0]          atan_s;
  logic                          y_pos;
  logic [AW-2:0]                 z_pos;
  logic [AW-1:0]                 z_rnd;
  logic [cad_pkg::DIST_W-1:0]    dist_fin;
  logic                          out_free;

  assign acc_add = mplr_r[0] ? acc_r + mcand_r : acc_r;
  assign acc_sub = mplr_r[0] ? acc_r - mcand_r : acc_r;
  assign dot_mag = dot_r[cad_pkg::DOT_W-1] ? cad_pkg::NORM_W'(-dot_r)
                                           : cad_pkg::NORM_W'(dot_r);

  assign rem_sh = {rem_r[RW+1:0], rad_r[2*RW-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};

  assign x_mag  = x_r[CW-1] ? CW'(-x_r) : CW'(x_r);
  assign xs     = x_r >>> cnt_r[4:0];
  assign ys     = y_r >>> cnt_r[4:0];
  assign atan_s = $signed({4'b0000, cad_pkg::atan_tab(cnt_r[4:0])});
  assign y_pos  = !y_r[CW-1] && (y_r != '0);

  // Clamp negative angle to zero, round to pi/2^16 and saturate.
  assign z_pos = z_r[AW-1] ? '0 : z_r[AW-2:0];
  assign z_rnd = {1'b0, z_pos} + AW'(128);
  assign dist_fin = (z_rnd[AW-1:8] > 19'd65535) ? 16'hFFFF : z_rnd[23:8];

  assign out_free = !out_valid_r || out_chan.ready;
  assign q_pop    = (state_r == S_IDLE) && q_not_empty;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.distance   = out_dist_r;
  assign out_chan.degenerate = out_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_not_empty) begin
            dot_r   <= q_head.dot;
            mcand_r <= PW'(q_head.n1);
            mplr_r  <= q_head.n2;
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_MULP;
          end
        end
        S_MULP: begin
          acc_r   <= acc_add;
          mcand_r <= mcand_r << 1;
          mplr_r  <= mplr_r >> 1;
          cnt_r   <= cnt_r + 6'd1;
          if (cnt_r == 6'(cad_pkg::NORM_W - 1)) begin
            cnt_r   <= '0;
            degen_r <= acc_add <= cad_pkg::DEGEN_LIMIT;
            mcand_r <= PW'(dot_mag);
            mplr_r  <= dot_mag;
            state_r <= (acc_add <= cad_pkg::DEGEN_LIMIT) ? S_DONE : S_MULD;
          end
        end
        S_MULD: begin
          acc_r   <= acc_sub;
          mcand_r <= mcand_r << 1;
          mplr_r  <= mplr_r >> 1;
          cnt_r   <= cnt_r + 6'd1;
          if (cnt_r == 6'(cad_pkg::NORM_W - 1)) begin
            cnt_r   <= '0;
            rad_r   <= (2*RW)'(acc_sub);
            rem_r   <= '0;
            root_r  <= '0;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          rad_r <= rad_r << 2;
          cnt_r <= cnt_r + 6'd1;
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[RW-2:0], 1'b0};
          end
          if (cnt_r == 6'(RW - 1)) begin
            cnt_r   <= '0;
            x_r     <= CW'(dot_r);
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (cnt_r == '0) begin
            // first cycle: pick up the finished root
            y_r   <= $signed(CW'(root_r));
            cnt_r <= 6'd1;
          end else if (x_mag >= NORM_LIM || $unsigned(y_r) >= NORM_LIM) begin
            cnt_r <= '0;
            if (x_r[CW-1]) begin
              x_r <= y_r;
              y_r <= -x_r;
              z_r <= cad_pkg::ANG_QUARTER;
            end else begin
              z_r <= '0;
            end
            state_r <= S_CORD;
          end else begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end
        end
        S_CORD: begin
          cnt_r <= cnt_r + 6'd1;
          if (y_pos) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + atan_s;
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - atan_s;
          end
          if (cnt_r == 6'(cad_pkg::CORD_STEPS - 1)) begin
            cnt_r   <= '0;
            degen_r <= 1'b0;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_dist_r  <= degen_r ? '0 : dist_fin;
            out_degen_r <= degen_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_degen_r) |-> (out_dist_r == '0))
    else $error("degenerate result with nonzero distance");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_MULP)) else $error("pop did not start a job");
`endif

endmodule
`default_nettype wire
